@@ src/tcgr_pkg.sv @@
// Shared types, codes and color helpers for the text cell glyph row renderer.
// Standalone package; no dependencies.
`default_nettype none

package tcgr_pkg;

  typedef logic [23:0] rgb_t;

  // request codes
  localparam logic [2:0] REQ_LOAD_FONT = 3'd0;
  localparam logic [2:0] REQ_LOAD_PAL  = 3'd1;
  localparam logic [2:0] REQ_CELL      = 3'd2;
  localparam logic [2:0] REQ_CURSOR    = 3'd3;
  localparam logic [2:0] REQ_EXPLICIT  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_RED_SHIFT   = 3'd0;
  localparam logic [2:0] REG_GREEN_SHIFT = 3'd1;
  localparam logic [2:0] REG_BLUE_SHIFT  = 3'd2;
  localparam logic [2:0] REG_DEFAULT_FG  = 3'd3;
  localparam logic [2:0] REG_DEFAULT_BG  = 3'd4;

  // attribute bits
  localparam int ATTR_DEF_FG    = 0;
  localparam int ATTR_DEF_BG    = 1;
  localparam int ATTR_REVERSE   = 2;
  localparam int ATTR_BOLD      = 3;
  localparam int ATTR_DIM       = 4;
  localparam int ATTR_HIDDEN    = 5;
  localparam int ATTR_UNDERLINE = 6;

  localparam rgb_t DIM_MASK = 24'h7f7f7f;
  localparam int   FONT_ROW_W = 16;

  // c * 3 / 2, saturated at 255
  function automatic logic [7:0] bright_chan(input logic [7:0] c);
    logic [8:0] s;
    s = {1'b0, c} + {2'b00, c[7:1]};
    return s[8] ? 8'hff : s[7:0];
  endfunction

  function automatic rgb_t brighten(input rgb_t c);
    return {bright_chan(c[23:16]), bright_chan(c[15:8]), bright_chan(c[7:0])};
  endfunction

  function automatic logic [31:0] pack_rgb(input rgb_t c, input logic [4:0] rs,
                                           input logic [4:0] gs, input logic [4:0] bs);
    return ({24'd0, c[23:16]} << rs) | ({24'd0, c[15:8]} << gs) | ({24'd0, c[7:0]} << bs);
  endfunction

endpackage

`default_nettype wire

@@ src/text_cell_glyph_row_renderer.sv @@
// Text cell glyph row renderer: font and palette stores, color pipeline, pixel serializer.
// Depends on tcgr_pkg.
`default_nettype none

// Load items (font row, palette entry) produce nothing. A render item (cell,
// cursor or explicit color) produces GLYPH_WIDTH pixel items, one per cycle
// while out_ready holds, the last one flagged by last_pixel. The pixel
// serializer paces the render items, while the stages ahead of it (store
// read, color select and bold, dim and pixel packing) work on the following
// items meanwhile and stop accepting once they are full. Font and palette
// stores are not cleared at reset; read an entry only after loading it.
module text_cell_glyph_row_renderer
  import tcgr_pkg::*;
#(
  parameter int GLYPH_WIDTH     = 8,
  parameter int GLYPH_HEIGHT    = 16,
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  req_type,
  input  wire logic [7:0]  char_code,
  input  wire logic [4:0]  glyph_row,
  input  wire logic [7:0]  fg_index,
  input  wire logic [7:0]  bg_index,
  input  wire logic [6:0]  attributes,
  input  wire logic [23:0] load_data,
  input  wire logic [23:0] fg_color,
  input  wire logic [23:0] bg_color,
  // pixel channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      pixel,
  output logic             last_pixel
);

  localparam int FONT_DEPTH = 256 * GLYPH_HEIGHT;
  localparam int FA_W       = $clog2(FONT_DEPTH);
  localparam int PA_W       = $clog2(PALETTE_ENTRIES);
  localparam int COL_W      = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;

  // configuration registers
  logic [4:0] red_shift, green_shift, blue_shift;
  rgb_t       default_fg, default_bg;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_shift   <= 5'd16;
      green_shift <= 5'd8;
      blue_shift  <= 5'd0;
      default_fg  <= 24'hffffff;
      default_bg  <= 24'h000000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RED_SHIFT:   red_shift   <= cfg_data[4:0];
        REG_GREEN_SHIFT: green_shift <= cfg_data[4:0];
        REG_BLUE_SHIFT:  blue_shift  <= cfg_data[4:0];
        REG_DEFAULT_FG:  default_fg  <= cfg_data;
        REG_DEFAULT_BG:  default_bg  <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic s1_valid, s2_valid, s3_valid;
  logic s1_ready, s2_ready, s3_ready;
  logic s3_last, out_load;
  logic [COL_W-1:0] s3_col;

  assign s3_last  = (s3_col == COL_W'(GLYPH_WIDTH - 1));
  assign out_load = s3_valid && (!out_valid || out_ready);
  assign s3_ready = !s3_valid || ((!out_valid || out_ready) && s3_last);
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  logic accept, is_render, row_ok, fg_ok, bg_ok, is_cell;
  logic [FA_W-1:0] font_addr;

  assign accept    = in_valid && in_ready;
  assign is_cell   = (req_type == REQ_CELL);
  assign is_render = is_cell || (req_type == REQ_CURSOR) || (req_type == REQ_EXPLICIT);
  assign row_ok    = ({1'b0, glyph_row} < 6'(GLYPH_HEIGHT));
  assign fg_ok     = ({1'b0, fg_index} < 9'(PALETTE_ENTRIES));
  assign bg_ok     = ({1'b0, bg_index} < 9'(PALETTE_ENTRIES));
  assign font_addr = row_ok ? (FA_W'(char_code) * FA_W'(GLYPH_HEIGHT) + FA_W'(glyph_row))
                            : '0;

  // stores: one write port, registered reads taken when an item is accepted
  logic [FONT_ROW_W-1:0] font_mem [FONT_DEPTH];
  rgb_t                  pal_mem  [PALETTE_ENTRIES];
  logic [FONT_ROW_W-1:0] font_q;
  rgb_t                  pal_fg_q, pal_bg_q;

  always_ff @(posedge clk) begin
    if (accept && req_type == REQ_LOAD_FONT && row_ok) begin
      font_mem[font_addr] <= load_data[FONT_ROW_W-1:0];
    end
    if (accept) begin
      font_q <= font_mem[font_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req_type == REQ_LOAD_PAL && fg_ok) begin
      pal_mem[fg_index[PA_W-1:0]] <= load_data;
    end
    if (accept) begin
      pal_fg_q <= pal_mem[fg_index[PA_W-1:0]];
      pal_bg_q <= pal_mem[bg_index[PA_W-1:0]];
    end
  end

  // stage 1: item fields beside the store read data
  logic       s1_cell, s1_cursor, s1_explicit, s1_row_ok, s1_fg_ok, s1_bg_ok, s1_under;
  logic [6:0] s1_attr;
  rgb_t       s1_fg_color, s1_bg_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= accept && is_render;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cell     <= is_cell;
      s1_cursor   <= (req_type == REQ_CURSOR);
      s1_explicit <= (req_type == REQ_EXPLICIT);
      s1_row_ok   <= row_ok;
      s1_fg_ok    <= fg_ok;
      s1_bg_ok    <= bg_ok;
      s1_attr     <= attributes;
      s1_fg_color <= fg_color;
      s1_bg_color <= bg_color;
      // the underline row is always inside the glyph
      s1_under    <= is_cell && attributes[ATTR_UNDERLINE]
                     && ({1'b0, glyph_row} == 6'(GLYPH_HEIGHT - 2));
    end
  end

  // color select, swap, bold
  rgb_t fg_sel, bg_sel, fg_sw, bg_sw, fg_b;
  logic swap;

  always_comb begin
    if (s1_explicit) begin
      fg_sel = s1_fg_color;
      bg_sel = s1_bg_color;
    end else begin
      fg_sel = s1_attr[ATTR_DEF_FG] ? default_fg : (s1_fg_ok ? pal_fg_q : '0);
      bg_sel = s1_attr[ATTR_DEF_BG] ? default_bg : (s1_bg_ok ? pal_bg_q : '0);
    end
    swap  = s1_cursor || (s1_cell && s1_attr[ATTR_REVERSE]);
    fg_sw = swap ? bg_sel : fg_sel;
    bg_sw = swap ? fg_sel : bg_sel;
    fg_b  = (s1_cell && s1_attr[ATTR_BOLD]) ? brighten(fg_sw) : fg_sw;
  end

  // stage 2
  rgb_t                   s2_fg, s2_bg;
  logic                   s2_dim, s2_hidden, s2_under;
  logic [GLYPH_WIDTH-1:0] s2_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_fg     <= fg_b;
      s2_bg     <= bg_sw;
      s2_dim    <= s1_cell && s1_attr[ATTR_DIM];
      s2_hidden <= s1_cell && s1_attr[ATTR_HIDDEN];
      s2_under  <= s1_under;
      s2_bits   <= s1_row_ok ? font_q[FONT_ROW_W-1 -: GLYPH_WIDTH] : '0;
    end
  end

  // dim, hidden, pack both colors
  rgb_t        fg_d, fg_h;
  logic [31:0] ink_px, bg_px;

  always_comb begin
    fg_d   = s2_dim ? ((s2_fg >> 1) & DIM_MASK) : s2_fg;
    fg_h   = s2_hidden ? s2_bg : fg_d;
    ink_px = pack_rgb(fg_h, red_shift, green_shift, blue_shift);
    bg_px  = pack_rgb(s2_bg, red_shift, green_shift, blue_shift);
  end

  // stage 3: row serializer, leftmost column in the top bit
  logic [31:0]            s3_ink, s3_bg;
  logic                   s3_under;
  logic [GLYPH_WIDTH-1:0] s3_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s3_col   <= '0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
      s3_col   <= '0;
    end else if (out_load) begin
      s3_col <= COL_W'(s3_col + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      s3_ink   <= ink_px;
      s3_bg    <= bg_px;
      s3_under <= s2_under;
      s3_bits  <= s2_bits;
    end else if (out_load) begin
      s3_bits <= s3_bits << 1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pixel      <= (s3_bits[GLYPH_WIDTH-1] || s3_under) ? s3_ink : s3_bg;
      last_pixel <= s3_last;
    end
  end

  // a row never stalls midway on the block's side
  a_row_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_pixel |=> out_valid)
    else $error("pixel row broken before its last pixel");

  // loads never enter the render pipeline
  a_load_no_render: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (req_type == REQ_LOAD_FONT || req_type == REQ_LOAD_PAL)
    |=> !s1_valid)
    else $error("load item entered render pipeline");

  // serializer column stays inside the glyph
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> ({1'b0, s3_col} <= (COL_W + 1)'(GLYPH_WIDTH - 1)))
    else $error("serializer column out of range");

endmodule

`default_nettype wire
